// ===== sv/rpnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpnc_pkg
// Shared constants and types of the postfix digit stack calculator: the
// character codes it decodes, its status codes and the request to its
// arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpnc_pkg;

  localparam int unsigned STACK_DEPTH_DFLT = 16;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned SYM_W            = 8;
  localparam int unsigned STATUS_W         = 3;

  // Character codes.
  localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_CALC  = 8'h63;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESULT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FEW     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== sv/rpnc_ram.sv =====
// ----------------------------------------------------------------------------
// rpnc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpnc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/rpnc_alu.sv =====
// ----------------------------------------------------------------------------
// rpnc_alu
// Shared arithmetic unit. Add, subtract and multiply finish in the cycle after
// start; divide runs a restoring loop of one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpnc_alu (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rpnc_pkg::alu_req_t                req,
  input  wire logic [rpnc_pkg::DATA_W-1:0]       lhs,
  input  wire logic [rpnc_pkg::DATA_W-1:0]       rhs,
  output logic                                   done,
  output logic      [rpnc_pkg::DATA_W-1:0]       result
);

  localparam int unsigned W     = rpnc_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_r,  busy_nxt;
  logic             done_r,  done_nxt;
  logic [CNT_W-1:0] bit_r,   bit_nxt;
  logic             neg_r,   neg_nxt;
  logic [W-1:0]     rem_r,   rem_nxt;
  logic [W-1:0]     quo_r,   quo_nxt;
  logic [W-1:0]     dvs_r,   dvs_nxt;
  logic [W-1:0]     res_r,   res_nxt;

  logic [W:0]       shifted;
  logic [W:0]       trial;
  logic [W-1:0]     quo_step;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    res_nxt  = res_r;

    // One restoring step: shift the next dividend bit into the remainder.
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    quo_step = {quo_r[W-2:0], ~trial[W]};

    if (busy_r) begin
      quo_nxt = quo_step;
      rem_nxt = trial[W] ? shifted[W-1:0] : trial[W-1:0];
      bit_nxt = bit_r - 1'b1;
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (-quo_step) : quo_step;
      end
    end else if (req.start) begin
      case (req.op)
        rpnc_pkg::OP_ADD: begin
          res_nxt  = lhs + rhs;
          done_nxt = 1'b1;
        end
        rpnc_pkg::OP_SUB: begin
          res_nxt  = lhs - rhs;
          done_nxt = 1'b1;
        end
        rpnc_pkg::OP_MUL: begin
          res_nxt  = lhs * rhs;
          done_nxt = 1'b1;
        end
        rpnc_pkg::OP_DIV: begin
          busy_nxt = 1'b1;
          bit_nxt  = CNT_W'(W - 1);
          neg_nxt  = lhs[W-1] ^ rhs[W-1];
          rem_nxt  = '0;
          quo_nxt  = lhs[W-1] ? (-lhs) : lhs;
          dvs_nxt  = rhs[W-1] ? (-rhs) : rhs;
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// ===== sv/postfix_digit_stack_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// postfix_digit_stack_calculator_unit
// Reverse Polish calculator over a stack of signed 32-bit operands, fed one
// ASCII character per input beat and giving one status beat per character.
//
// Usage:
// - Input channel in_valid/in_ready carries in_symbol. The unit takes one
//   character at a time; in_ready is high only while the sequencer is idle.
// - Result channel out_valid/out_ready carries out_status and out_value,
//   one beat for every input beat, in order.
// - Every character is decoded and its status then waits for the output
//   register. For 'c' the top of stack is read first; for + - * / the right
//   and then the left operand are read through the stack RAM's single read
//   port, and the shared arithmetic unit then computes the result, a divide
//   running 32 quotient-bit steps. A divide by zero is caught before the
//   unit is started.
// - The next character is accepted in the cycle after the previous result has
//   been loaded into the output register, never while one is in progress.
// - When the receiver stalls, the finished result is held in the sequencer
//   until the output register frees up, and no new character is taken.
// - Reset empties the stack and clears both channels; the operand RAM is
//   left as is, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_digit_stack_calculator_unit #(
  parameter int unsigned STACK_DEPTH = rpnc_pkg::STACK_DEPTH_DFLT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic        [rpnc_pkg::SYM_W-1:0]    in_symbol,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [rpnc_pkg::STATUS_W-1:0] out_status,
  output logic signed      [rpnc_pkg::DATA_W-1:0]   out_value
);

  localparam int unsigned PTR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W     = rpnc_pkg::DATA_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RHS  = 7'b0000100,
    S_LHS  = 7'b0001000,
    S_EXEC = 7'b0010000,
    S_TOP  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r,   cnt_nxt;
  logic [rpnc_pkg::SYM_W-1:0]     sym_r,   sym_nxt;
  logic [rpnc_pkg::STATUS_W-1:0]  st_r,    st_nxt;
  logic [W-1:0]                   val_r,   val_nxt;
  logic [W-1:0]                   rhs_r,   rhs_nxt;

  logic                           out_valid_r;
  logic [rpnc_pkg::STATUS_W-1:0]  out_status_r;
  logic [W-1:0]                   out_value_r;

  logic                           wr_en;
  logic [PTR_W-1:0]               wr_addr;
  logic [W-1:0]                   wr_data;
  logic [PTR_W-1:0]               rd_addr;
  logic [W-1:0]                   rd_data;

  rpnc_pkg::alu_req_t             alu_req;
  logic                           alu_done;
  logic [W-1:0]                   alu_result;

  logic                           is_digit;
  logic                           is_op;
  logic                           is_blank;
  logic                           is_full;
  logic                           out_free;
  logic [PTR_W-1:0]               top_idx;
  logic [PTR_W-1:0]               below_idx;
  rpnc_pkg::alu_op_t              op_sel;

  assign is_digit  = (sym_r >= rpnc_pkg::CH_ZERO) && (sym_r <= rpnc_pkg::CH_NINE);
  assign is_op     = (sym_r == rpnc_pkg::CH_ADD) || (sym_r == rpnc_pkg::CH_SUB) ||
                     (sym_r == rpnc_pkg::CH_MUL) || (sym_r == rpnc_pkg::CH_DIV);
  assign is_blank  = (sym_r == rpnc_pkg::CH_SPACE) ||
                     ((sym_r >= rpnc_pkg::CH_TAB) && (sym_r <= rpnc_pkg::CH_CR));
  assign is_full   = (cnt_r == CNT_W'(STACK_DEPTH));
  assign out_free  = !out_valid_r || out_ready;
  assign top_idx   = PTR_W'(cnt_r - 1'b1);
  assign below_idx = PTR_W'(cnt_r - 2'd2);

  always_comb begin
    case (sym_r)
      rpnc_pkg::CH_ADD: op_sel = rpnc_pkg::OP_ADD;
      rpnc_pkg::CH_SUB: op_sel = rpnc_pkg::OP_SUB;
      rpnc_pkg::CH_MUL: op_sel = rpnc_pkg::OP_MUL;
      default:          op_sel = rpnc_pkg::OP_DIV;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sym_nxt   = sym_r;
    st_nxt    = st_r;
    val_nxt   = val_r;
    rhs_nxt   = rhs_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_addr   = '0;
    alu_req   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt   = in_symbol;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        st_nxt    = rpnc_pkg::ST_OK;
        val_nxt   = '0;
        state_nxt = S_FIN;
        if (is_digit) begin
          if (is_full) begin
            st_nxt = rpnc_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = PTR_W'(cnt_r);
            wr_data = W'(sym_r - rpnc_pkg::CH_ZERO);
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (is_op) begin
          if (cnt_r < CNT_W'(2)) begin
            st_nxt = rpnc_pkg::ST_FEW;
          end else begin
            rd_addr   = top_idx;
            state_nxt = S_RHS;
          end
        end else if (sym_r == rpnc_pkg::CH_CALC) begin
          cnt_nxt = '0;
          if (cnt_r == '0) begin
            st_nxt = rpnc_pkg::ST_EMPTY;
          end else begin
            rd_addr   = top_idx;
            state_nxt = S_TOP;
          end
        end else if (!is_blank) begin
          st_nxt  = rpnc_pkg::ST_INVALID;
          cnt_nxt = '0;
        end
      end
      S_RHS: begin
        rhs_nxt   = rd_data;
        rd_addr   = below_idx;
        state_nxt = S_LHS;
      end
      S_LHS: begin
        // The left operand arrives from the RAM in this cycle.
        if ((op_sel == rpnc_pkg::OP_DIV) && (rhs_r == '0)) begin
          st_nxt    = rpnc_pkg::ST_DIVZERO;
          state_nxt = S_FIN;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = op_sel;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          wr_en     = 1'b1;
          wr_addr   = below_idx;
          wr_data   = alu_result;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_TOP: begin
        st_nxt    = rpnc_pkg::ST_RESULT;
        val_nxt   = rd_data;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    sym_r <= sym_nxt;
    st_r  <= st_nxt;
    val_r <= val_nxt;
    rhs_r <= rhs_nxt;
    if ((state_r == S_FIN) && out_free) begin
      out_status_r <= st_r;
      out_value_r  <= val_r;
    end
  end

  rpnc_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpnc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (rd_data),
    .rhs    (rhs_r),
    .done   (alu_done),
    .result (alu_result)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

`default_nettype wire
